// ===== rtl/wildcard_transition_best_match_unit_defines.svh =====
// assertion macros for the wildcard transition best match unit
// expects clk_i and rst_ni in the scope of every use
`ifndef WILDCARD_TRANSITION_BEST_MATCH_UNIT_DEFINES_SVH
`define WILDCARD_TRANSITION_BEST_MATCH_UNIT_DEFINES_SVH

// condition holds at every edge out of reset
`define WTBM_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("wtbm: invariant violated");

// consequent holds in the same cycle
`define WTBM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("wtbm: implication violated");

// consequent holds in the next cycle
`define WTBM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("wtbm: next-cycle implication violated");

`endif

// ===== rtl/wtbm_pkg.sv =====
// shared types and constants of the wildcard transition best match unit
// no dependencies
package wtbm_pkg;

  localparam int MAX_ENTRIES_DEF     = 64;
  localparam int MAX_GROUPS_DEF      = 16;
  localparam int STATE_BITS_DEF      = 8;
  localparam int TRANSITION_BITS_DEF = 10;
  localparam int GROUP_BITS          = 4;

  localparam logic REQ_RECORD = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef logic [1:0] score_t;

  localparam score_t SCORE_NONE = 2'd0;
  localparam score_t SCORE_SRC  = 2'd1;
  localparam score_t SCORE_DST  = 2'd2;

  // token and running best score handed from cell to cell
  typedef struct packed {
    logic   tok;
    score_t score;
  } link_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESP
  } state_e;

endpackage

// ===== rtl/wtbm_cell.sv =====
// one table entry of the scan chain: stores the entry and scores it against the query
// depends on wtbm_pkg
module wtbm_cell #(
  parameter int IDX = 0,
  parameter int CW  = 7,
  parameter int IW  = 6,
  parameter int SB  = wtbm_pkg::STATE_BITS_DEF,
  parameter int TB  = wtbm_pkg::TRANSITION_BITS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [CW-1:0]   count_i,
  input  logic            wr_en_i,
  input  logic [IW-1:0]   wr_idx_i,
  input  logic            wr_fk_i,
  input  logic [SB-1:0]   wr_fs_i,
  input  logic            wr_tk_i,
  input  logic [SB-1:0]   wr_ts_i,
  input  logic [TB-1:0]   wr_trans_i,
  input  logic            q_fk_i,
  input  logic [SB-1:0]   q_fs_i,
  input  logic [SB-1:0]   q_ts_i,
  input  wtbm_pkg::link_t link_i,
  input  logic [TB-1:0]   pick_i,
  output wtbm_pkg::link_t link_o,
  output logic [TB-1:0]   pick_o
);

  logic            fk_q;
  logic [SB-1:0]   fs_q;
  logic            tk_q;
  logic [SB-1:0]   ts_q;
  logic [TB-1:0]   trans_q;

  wtbm_pkg::link_t link_q;
  logic [TB-1:0]   pick_q;

  logic             active;
  logic             src_match;
  logic             dst_match;
  logic             clash;
  wtbm_pkg::score_t score_c;
  logic             win;

  // entry payload, written once when the record lands on this slot
  always_ff @(posedge clk_i) begin
    if (wr_en_i && (wr_idx_i == IW'(IDX))) begin
      fk_q    <= wr_fk_i;
      fs_q    <= wr_fs_i;
      tk_q    <= wr_tk_i;
      ts_q    <= wr_ts_i;
      trans_q <= wr_trans_i;
    end
  end

  always_comb begin
    active    = CW'(IDX) < count_i;
    // an unknown query source only matches a wildcard source
    src_match = (fk_q == q_fk_i) && (!q_fk_i || (fs_q == q_fs_i));
    dst_match = tk_q && (ts_q == q_ts_i);
    clash     = (fk_q && !src_match) || (tk_q && !dst_match);
    score_c   = (src_match ? wtbm_pkg::SCORE_SRC : wtbm_pkg::SCORE_NONE)
              | (dst_match ? wtbm_pkg::SCORE_DST : wtbm_pkg::SCORE_NONE);
    // strict compare keeps the earliest entry on a tie
    win       = active && !clash && (score_c > link_i.score);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q <= '0;
    end else begin
      link_q.tok <= link_i.tok;
      if (link_i.tok) begin
        link_q.score <= win ? score_c : link_i.score;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (link_i.tok) begin
      pick_q <= win ? trans_q : pick_i;
    end
  end

  assign link_o = link_q;
  assign pick_o = pick_q;

endmodule

// ===== rtl/wtbm_dflt.sv =====
// per-group default transitions: valid flags in flops, transitions in a small memory
// depends on wtbm_pkg
module wtbm_dflt #(
  parameter int MAX_GROUPS = wtbm_pkg::MAX_GROUPS_DEF,
  parameter int TB         = wtbm_pkg::TRANSITION_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            wr_en_i,
  input  logic                            rd_en_i,
  input  logic [wtbm_pkg::GROUP_BITS-1:0] grp_i,
  input  logic [TB-1:0]                   wr_trans_i,
  output logic                            rd_valid_o,
  output logic [TB-1:0]                   rd_trans_o
);

  localparam int GIW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;

  logic [MAX_GROUPS-1:0] valid_q;
  logic [TB-1:0]         mem_q [MAX_GROUPS];
  logic                  rd_valid_q;
  logic [TB-1:0]         rd_trans_q;

  logic           in_range;
  logic [GIW-1:0] gidx;

  assign in_range = int'(grp_i) < MAX_GROUPS;
  assign gidx     = GIW'(grp_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i && in_range) begin
        valid_q[gidx] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= in_range && valid_q[gidx];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i && in_range) begin
      mem_q[gidx] <= wr_trans_i;
    end
    if (rd_en_i) begin
      rd_trans_q <= mem_q[gidx];
    end
  end

  assign rd_valid_o = rd_valid_q;
  assign rd_trans_o = rd_trans_q;

endmodule

// ===== rtl/wildcard_transition_best_match_unit.sv =====
// A record item appends one entry to a chain of MAX_ENTRIES cells; a full table refuses it with
// status 1. A lookup item sends a token with the running best score down the chain, one cell per
// cycle. The group default is read from its memory when the lookup is taken. The result sits in
// an output register, so a new item is taken while it waits.
// depends on wtbm_pkg, wtbm_cell, wtbm_dflt and the defines header
`include "wildcard_transition_best_match_unit_defines.svh"

module wildcard_transition_best_match_unit #(
  parameter int MAX_ENTRIES     = wtbm_pkg::MAX_ENTRIES_DEF,
  parameter int MAX_GROUPS      = wtbm_pkg::MAX_GROUPS_DEF,
  parameter int STATE_BITS      = wtbm_pkg::STATE_BITS_DEF,
  parameter int TRANSITION_BITS = wtbm_pkg::TRANSITION_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            req_type_i,
  input  logic [wtbm_pkg::GROUP_BITS-1:0] group_index_i,
  input  logic [STATE_BITS-1:0]           from_state_i,
  input  logic                            from_known_i,
  input  logic [STATE_BITS-1:0]           to_state_i,
  input  logic                            to_known_i,
  input  logic                            both_names_empty_i,
  input  logic [TRANSITION_BITS-1:0]      transition_number_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            found_o,
  output logic [TRANSITION_BITS-1:0]      result_transition_o,
  output logic                            status_o
);

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  wtbm_pkg::state_e state_q, state_d;

  logic [CW-1:0]              count_q;
  logic                       start_q;
  logic                       lookup_q;
  logic                       full_q;
  logic                       q_fk_q;
  logic [STATE_BITS-1:0]      q_fs_q;
  logic [STATE_BITS-1:0]      q_ts_q;

  logic                       out_valid_q;
  logic                       found_q;
  logic [TRANSITION_BITS-1:0] trans_q;
  logic                       status_q;

  logic acc;
  logic is_rec;
  logic full;
  logic rec_ok;
  logic out_load;

  logic                       dflt_valid;
  logic [TRANSITION_BITS-1:0] dflt_trans;

  wtbm_pkg::link_t            link [MAX_ENTRIES+1];
  logic [TRANSITION_BITS-1:0] pick [MAX_ENTRIES+1];
  logic [MAX_ENTRIES-1:0]     tok_vec;

  logic                       have;
  logic                       res_found;
  logic [TRANSITION_BITS-1:0] res_trans;

  assign in_ready_o = (state_q == wtbm_pkg::ST_IDLE);
  assign acc        = in_valid_i && in_ready_o;
  assign is_rec     = (req_type_i == wtbm_pkg::REQ_RECORD);
  assign full       = (count_q == CW'(MAX_ENTRIES));
  assign rec_ok     = acc && is_rec && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= wtbm_pkg::ST_IDLE;
      count_q  <= '0;
      start_q  <= 1'b0;
      lookup_q <= 1'b0;
      full_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      start_q <= acc && !is_rec;
      if (rec_ok) begin
        count_q <= count_q + CW'(1);
      end
      if (acc) begin
        lookup_q <= !is_rec;
        full_q   <= is_rec && full;
      end
    end
  end

  // query held steady while the token walks the chain
  always_ff @(posedge clk_i) begin
    if (acc && !is_rec) begin
      q_fk_q <= from_known_i;
      q_fs_q <= from_state_i;
      q_ts_q <= to_state_i;
    end
  end

  always_comb begin
    state_d  = state_q;
    out_load = 1'b0;
    case (state_q)
      wtbm_pkg::ST_IDLE: begin
        if (acc) begin
          state_d = is_rec ? wtbm_pkg::ST_RESP : wtbm_pkg::ST_SCAN;
        end
      end
      wtbm_pkg::ST_SCAN: begin
        if (link[MAX_ENTRIES].tok) begin
          state_d = wtbm_pkg::ST_RESP;
        end
      end
      wtbm_pkg::ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = wtbm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = wtbm_pkg::ST_IDLE;
      end
    endcase
  end

  assign link[0] = '{tok: start_q, score: wtbm_pkg::SCORE_NONE};
  assign pick[0] = '0;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    wtbm_cell #(
      .IDX (i),
      .CW  (CW),
      .IW  (IW),
      .SB  (STATE_BITS),
      .TB  (TRANSITION_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .count_i    (count_q),
      .wr_en_i    (rec_ok),
      .wr_idx_i   (IW'(count_q)),
      .wr_fk_i    (from_known_i),
      .wr_fs_i    (from_state_i),
      .wr_tk_i    (to_known_i),
      .wr_ts_i    (to_state_i),
      .wr_trans_i (transition_number_i),
      .q_fk_i     (q_fk_q),
      .q_fs_i     (q_fs_q),
      .q_ts_i     (q_ts_q),
      .link_i     (link[i]),
      .pick_i     (pick[i]),
      .link_o     (link[i+1]),
      .pick_o     (pick[i+1])
    );
    assign tok_vec[i] = link[i+1].tok;
  end

  wtbm_dflt #(
    .MAX_GROUPS (MAX_GROUPS),
    .TB         (TRANSITION_BITS)
  ) u_dflt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (rec_ok && both_names_empty_i),
    .rd_en_i    (acc && !is_rec),
    .grp_i      (group_index_i),
    .wr_trans_i (transition_number_i),
    .rd_valid_o (dflt_valid),
    .rd_trans_o (dflt_trans)
  );

  always_comb begin
    have      = (link[MAX_ENTRIES].score != wtbm_pkg::SCORE_NONE);
    res_found = lookup_q && (have || dflt_valid);
    if (!lookup_q) begin
      res_trans = '0;
    end else if (have) begin
      res_trans = pick[MAX_ENTRIES];
    end else if (dflt_valid) begin
      res_trans = dflt_trans;
    end else begin
      res_trans = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      found_q  <= res_found;
      trans_q  <= res_trans;
      status_q <= full_q ? wtbm_pkg::STATUS_FULL : wtbm_pkg::STATUS_OK;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign found_o             = found_q;
  assign result_transition_o = trans_q;
  assign status_o            = status_q;

  `WTBM_ASSERT_ALWAYS(a_count_bound, count_q <= CW'(MAX_ENTRIES))
  `WTBM_ASSERT_ALWAYS(a_single_token, $onehot0(tok_vec))
  `WTBM_ASSERT_IMP(a_tail_in_scan, link[MAX_ENTRIES].tok, state_q == wtbm_pkg::ST_SCAN)
  `WTBM_ASSERT_NXT(a_full_no_grow, acc && is_rec && full, count_q == $past(count_q))
  `WTBM_ASSERT_IMP(a_found_ok, out_valid_o && found_o, status_o == wtbm_pkg::STATUS_OK)

endmodule
